[design/sabf_pkg.sv]
`timescale 1ns / 1ps

package sabf_pkg;

  // table sizes
  localparam int IPV4_SLOTS = 64;
  localparam int IPV6_SLOTS = 64;

  // ethertypes and minimum frame lengths
  localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6   = 16'h86DD;
  localparam logic [15:0] IPV4_MIN_LEN = 16'd34;
  localparam logic [15:0] IPV6_MIN_LEN = 16'd54;

  // field widths
  localparam int INDEX_W = 6;
  localparam int V4_W    = 32;
  localparam int V6_W    = 128;

  // item operations
  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_WR_V4 = 2'd1,
    OP_WR_V6 = 2'd2
  } op_t;

  // verdict kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_V4   = 2'd1;
  localparam logic [1:0] KIND_V6   = 2'd2;

  // search control travelling down a cell chain
  typedef struct packed {
    logic valid;
    logic hit;
  } query_ctl_t;

  // table write broadcast to every cell of a chain
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    logic               valid;
  } wr_ctl_t;

  // frame parse state
  typedef struct packed {
    logic [15:0] count;
    logic [15:0] etype;
    logic [63:0] src_up;
    logic [63:0] src_lo;
  } frame_t;

endpackage

[design/sabf_cell.sv]
`timescale 1ns / 1ps

module sabf_cell #(
  parameter int KEY_W = sabf_pkg::V4_W,
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sabf_pkg::wr_ctl_t     wr,
  input  logic [KEY_W-1:0]      wr_data,
  input  sabf_pkg::query_ctl_t  q_in,
  input  logic [KEY_W-1:0]      key_in,
  output sabf_pkg::query_ctl_t  q_out,
  output logic [KEY_W-1:0]      key_out
);

  logic [KEY_W-1:0] entry;
  logic             entry_valid;
  logic             match;
  logic             selected;

  // slot decode and compare against the passing key
  assign selected = wr.en && (int'(wr.index) == INDEX);
  assign match    = entry_valid && (entry == key_in);

  // slot storage
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (selected) begin
      entry_valid <= wr.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (selected && wr.valid) begin
      entry <= wr_data;
    end
  end

  // hand the query to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else begin
      q_out.valid <= q_in.valid;
    end
    q_out.hit <= q_in.hit | (q_in.valid & match);
    key_out   <= key_in;
  end

endmodule

[design/sabf_parser.sv]
`timescale 1ns / 1ps

module sabf_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_en,
  input  logic             clear,
  input  logic [7:0]       frame_byte,
  output sabf_pkg::frame_t frame_next
);

  sabf_pkg::frame_t frame;

  // per-byte update of count, ethertype and source capture
  always_comb begin
    frame_next = frame;
    if (frame.count == 16'd12) begin
      frame_next.etype = {frame_byte, frame.etype[7:0]};
    end else if (frame.count == 16'd13) begin
      frame_next.etype = {frame.etype[15:8], frame_byte};
    end else if (frame.count >= 16'd22 && frame.count <= 16'd29) begin
      frame_next.src_up = {frame.src_up[55:0], frame_byte};
    end else if (frame.count >= 16'd30 && frame.count <= 16'd37) begin
      frame_next.src_lo = {frame.src_lo[55:0], frame_byte};
    end
    if (frame.count != 16'hFFFF) begin
      frame_next.count = frame.count + 16'd1;
    end
  end

  // frame state, back to zero after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      frame <= '0;
    end else if (byte_en) begin
      if (clear) begin
        frame <= '0;
      end else begin
        frame <= frame_next;
      end
    end
  end

endmodule

[design/source_address_blocklist_filter.sv]
`timescale 1ns / 1ps

// channel  | handshake              | payload
// ---------+------------------------+--------------------------------------------
// in       | in_valid / in_stall    | op, frame_byte, last_byte, entry_index,
//          |                        | entry_valid, entry_addr_high, entry_addr_low
// out      | out_valid / out_stall  | drop, match_kind
//
// frame bytes that are not last, table writes and unknown ops are taken when
// the input does not stall. a last byte of a long enough IPv4 or IPv6 frame
// starts a search through the cell chain of that table, one cell per cycle, and
// the input stalls meanwhile; the verdict register takes the result of the last
// cell. other last bytes give their verdict in the next cycle. reset clears all
// valid marks at once. a stalled verdict stalls only a following last byte.
module source_address_blocklist_filter #(
  parameter int IPV4_SLOTS = sabf_pkg::IPV4_SLOTS,
  parameter int IPV6_SLOTS = sabf_pkg::IPV6_SLOTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  input  logic [5:0]  entry_index,
  input  logic        entry_valid,
  input  logic [63:0] entry_addr_high,
  input  logic [63:0] entry_addr_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        drop,
  output logic [1:0]  match_kind
);

  logic             accept;
  logic             byte_en;
  logic             frame_end;
  logic             v4_req;
  logic             v6_req;
  logic             busy;
  logic             out_take;
  sabf_pkg::frame_t frame_next;
  sabf_pkg::wr_ctl_t wr_v4;
  sabf_pkg::wr_ctl_t wr_v6;

  sabf_pkg::query_ctl_t          v4_ctl [0:IPV4_SLOTS];
  logic [sabf_pkg::V4_W-1:0]     v4_key [0:IPV4_SLOTS];
  sabf_pkg::query_ctl_t          v6_ctl [0:IPV6_SLOTS];
  logic [sabf_pkg::V6_W-1:0]     v6_key [0:IPV6_SLOTS];

  // handshake
  assign out_take  = out_valid & ~out_stall;
  assign in_stall  = busy | (out_valid & out_stall & (op == sabf_pkg::OP_FRAME) & last_byte);
  assign accept    = in_valid & ~in_stall;
  assign byte_en   = accept & (op == sabf_pkg::OP_FRAME);
  assign frame_end = byte_en & last_byte;

  // frame parsing
  sabf_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_en    (byte_en),
    .clear      (last_byte),
    .frame_byte (frame_byte),
    .frame_next (frame_next)
  );

  // which table the finished frame is looked up in
  assign v4_req = (frame_next.etype == sabf_pkg::ETYPE_IPV4) &&
                  (frame_next.count >= sabf_pkg::IPV4_MIN_LEN);
  assign v6_req = (frame_next.etype == sabf_pkg::ETYPE_IPV6) &&
                  (frame_next.count >= sabf_pkg::IPV6_MIN_LEN);

  // table write broadcasts
  always_comb begin
    wr_v4.en    = accept & (op == sabf_pkg::OP_WR_V4);
    wr_v4.index = entry_index;
    wr_v4.valid = entry_valid;
    wr_v6.en    = accept & (op == sabf_pkg::OP_WR_V6);
    wr_v6.index = entry_index;
    wr_v6.valid = entry_valid;
  end

  // search launch at the head of each chain
  assign v4_ctl[0].valid = frame_end & v4_req;
  assign v4_ctl[0].hit   = 1'b0;
  assign v4_key[0]       = frame_next.src_up[31:0];
  assign v6_ctl[0].valid = frame_end & v6_req;
  assign v6_ctl[0].hit   = 1'b0;
  assign v6_key[0]       = {frame_next.src_up, frame_next.src_lo};

  // IPv4 cell chain
  for (genvar i = 0; i < IPV4_SLOTS; i++) begin : g_v4
    sabf_cell #(
      .KEY_W (sabf_pkg::V4_W),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr_v4),
      .wr_data (entry_addr_low[31:0]),
      .q_in    (v4_ctl[i]),
      .key_in  (v4_key[i]),
      .q_out   (v4_ctl[i+1]),
      .key_out (v4_key[i+1])
    );
  end

  // IPv6 cell chain
  for (genvar i = 0; i < IPV6_SLOTS; i++) begin : g_v6
    sabf_cell #(
      .KEY_W (sabf_pkg::V6_W),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .wr      (wr_v6),
      .wr_data ({entry_addr_high, entry_addr_low}),
      .q_in    (v6_ctl[i]),
      .key_in  (v6_key[i]),
      .q_out   (v6_ctl[i+1]),
      .key_out (v6_key[i+1])
    );
  end

  // search in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (frame_end && (v4_req || v6_req)) begin
      busy <= 1'b1;
    end else if (v4_ctl[IPV4_SLOTS].valid || v6_ctl[IPV6_SLOTS].valid) begin
      busy <= 1'b0;
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (v4_ctl[IPV4_SLOTS].valid || v6_ctl[IPV6_SLOTS].valid ||
                 (frame_end && !v4_req && !v6_req)) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_ctl[IPV4_SLOTS].valid) begin
      drop       <= v4_ctl[IPV4_SLOTS].hit;
      match_kind <= v4_ctl[IPV4_SLOTS].hit ? sabf_pkg::KIND_V4 : sabf_pkg::KIND_NONE;
    end else if (v6_ctl[IPV6_SLOTS].valid) begin
      drop       <= v6_ctl[IPV6_SLOTS].hit;
      match_kind <= v6_ctl[IPV6_SLOTS].hit ? sabf_pkg::KIND_V6 : sabf_pkg::KIND_NONE;
    end else if (frame_end && !v4_req && !v6_req) begin
      drop       <= 1'b0;
      match_kind <= sabf_pkg::KIND_NONE;
    end
  end

endmodule
